// ===== hw/rtl/qsort_pkg.sv =====
// Shared types and constants for the quicksort sort engine.
// No dependencies; imported by quicksort_hoare_sort_engine.
`timescale 1ns / 1ps

package qsort_pkg;

   localparam int SAMPLE_W = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_PUSH,
      ST_POP,
      ST_POP_WAIT,
      ST_PIVOT_RD,
      ST_PIVOT_LD,
      ST_I_CHK,
      ST_J_CHK,
      ST_SWAP,
      ST_RESUME,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_EMIT_PRIME,
      ST_EMIT
   } state_type;

endpackage

// ===== hw/rtl/quicksort_hoare_sort_engine.sv =====
// Quicksort engine: element store, range stack and Hoare partition sequencer.
// Depends on qsort_pkg for the state type and the sample width.
`timescale 1ns / 1ps
//
//  channel   direction  transfer condition     signals
//  request   in         start & !busy          req_sample_value, req_is_final
//  response  out        rsp_strobe             rsp_sorted_value, rsp_run_end,
//                                              rsp_dropped_items
//
// Loading takes one item per cycle while busy is low. The item marked final starts the sort,
// during which busy stays high: each scan step of the partition goes through the single
// read port of the element store, each swap takes two writes and a resume read, and each
// range passes through pop, pivot fetch and push. Results then stream out one per
// cycle after a priming state and the output register. Reset is synchronous
// and clears control state only; no clearing pass runs. The receiver cannot stall.

module quicksort_hoare_sort_engine #(
   parameter int STORE_DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [qsort_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                  req_is_final,
   output logic                                  rsp_strobe,
   output logic signed [qsort_pkg::SAMPLE_W-1:0] rsp_sorted_value,
   output logic                                  rsp_run_end,
   output logic                                  rsp_dropped_items
);

   import qsort_pkg::*;

   localparam int EFF_W = (VALUE_WIDTH < SAMPLE_W) ? VALUE_WIDTH : SAMPLE_W;
   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [CNT_W-1:0]           sp_ff, sp_in;
   logic                       ovf_ff, ovf_in;
   logic [IDX_W-1:0]           lo_ff, lo_in;
   logic [IDX_W-1:0]           hi_ff, hi_in;
   logic [IDX_W-1:0]           i_ff, i_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic [IDX_W-1:0]           k_ff, k_in;
   logic signed [EFF_W-1:0]    pivot_ff, pivot_in;
   logic signed [EFF_W-1:0]    vi_ff, vi_in;
   logic                       strobe_ff, strobe_in;
   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic                       run_end_ff, run_end_in;
   logic                       dropped_ff, dropped_in;

   logic signed [EFF_W-1:0]    elem_mem [STORE_DEPTH];
   logic signed [EFF_W-1:0]    el_rd_ff;
   logic                       el_we;
   logic [IDX_W-1:0]           el_waddr;
   logic signed [EFF_W-1:0]    el_wdata;
   logic [IDX_W-1:0]           el_raddr;

   logic [2*IDX_W-1:0]         stk_mem [STORE_DEPTH];
   logic [2*IDX_W-1:0]         stk_rd_ff;
   logic                       stk_we;
   logic [IDX_W-1:0]           stk_waddr;
   logic [2*IDX_W-1:0]         stk_wdata;
   logic [IDX_W-1:0]           stk_raddr;

   logic [IDX_W-1:0]           last_idx;
   logic [IDX_W-1:0]           j_next;

   assign last_idx = IDX_W'(cnt_ff - CNT_W'(1));
   assign j_next   = j_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (el_we) begin
         elem_mem[el_waddr] <= el_wdata;
      end
      el_rd_ff <= elem_mem[el_raddr];
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         sp_ff     <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         sp_ff     <= sp_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= strobe_in;
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      pivot_ff   <= pivot_in;
      vi_ff      <= vi_in;
      value_ff   <= value_in;
      run_end_ff <= run_end_in;
      dropped_ff <= dropped_in;
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      sp_in      = sp_ff;
      ovf_in     = ovf_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      pivot_in   = pivot_ff;
      vi_in      = vi_ff;
      strobe_in  = 1'b0;
      value_in   = value_ff;
      run_end_in = run_end_ff;
      dropped_in = dropped_ff;
      el_we      = 1'b0;
      el_waddr   = i_ff;
      el_wdata   = el_rd_ff;
      el_raddr   = i_ff;
      stk_we     = 1'b0;
      stk_waddr  = sp_ff[IDX_W-1:0];
      stk_wdata  = {lo_ff, hi_ff};
      stk_raddr  = sp_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (cnt_ff != CNT_W'(STORE_DEPTH)) begin
                  el_we    = 1'b1;
                  el_waddr = cnt_ff[IDX_W-1:0];
                  el_wdata = req_sample_value[EFF_W-1:0];
                  cnt_in   = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_final) begin
                  if (cnt_in >= CNT_W'(2)) begin
                     state_in = ST_INIT_PUSH;
                  end else begin
                     state_in = ST_EMIT_PRIME;
                  end
               end
            end
         end
         ST_INIT_PUSH: begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = {IDX_W'(0), last_idx};
            sp_in     = CNT_W'(1);
            state_in  = ST_POP;
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_EMIT_PRIME;
            end else begin
               sp_in     = sp_ff - CNT_W'(1);
               stk_raddr = sp_in[IDX_W-1:0];
               state_in  = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            lo_in    = stk_rd_ff[2*IDX_W-1:IDX_W];
            hi_in    = stk_rd_ff[IDX_W-1:0];
            i_in     = stk_rd_ff[2*IDX_W-1:IDX_W];
            j_in     = stk_rd_ff[IDX_W-1:0];
            state_in = ST_PIVOT_RD;
         end
         ST_PIVOT_RD: begin
            el_raddr = lo_ff;
            state_in = ST_PIVOT_LD;
         end
         ST_PIVOT_LD: begin
            pivot_in = el_rd_ff;
            el_raddr = i_ff;
            state_in = ST_I_CHK;
         end
         ST_I_CHK: begin
            if (i_ff != hi_ff && el_rd_ff < pivot_ff) begin
               i_in     = i_ff + IDX_W'(1);
               el_raddr = i_in;
            end else begin
               vi_in    = el_rd_ff;
               el_raddr = j_ff;
               state_in = ST_J_CHK;
            end
         end
         ST_J_CHK: begin
            if (j_ff != lo_ff && el_rd_ff > pivot_ff) begin
               j_in     = j_ff - IDX_W'(1);
               el_raddr = j_in;
            end else if (i_ff < j_ff) begin
               el_we    = 1'b1;
               el_waddr = i_ff;
               el_wdata = el_rd_ff;
               state_in = ST_SWAP;
            end else begin
               if (j_ff == hi_ff) begin
                  j_in = hi_ff - IDX_W'(1);
               end
               state_in = ST_PUSH_A;
            end
         end
         ST_SWAP: begin
            el_we    = 1'b1;
            el_waddr = j_ff;
            el_wdata = vi_ff;
            i_in     = i_ff + IDX_W'(1);
            j_in     = j_ff - IDX_W'(1);
            state_in = ST_RESUME;
         end
         ST_RESUME: begin
            el_raddr = i_ff;
            state_in = ST_I_CHK;
         end
         ST_PUSH_A: begin
            if (j_next != hi_ff) begin
               stk_we    = 1'b1;
               stk_wdata = {j_next, hi_ff};
               sp_in     = sp_ff + CNT_W'(1);
            end
            state_in = ST_PUSH_B;
         end
         ST_PUSH_B: begin
            if (lo_ff != j_ff) begin
               stk_we    = 1'b1;
               stk_wdata = {lo_ff, j_ff};
               sp_in     = sp_ff + CNT_W'(1);
            end
            state_in = ST_POP;
         end
         ST_EMIT_PRIME: begin
            k_in     = '0;
            el_raddr = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in  = 1'b1;
            value_in   = SAMPLE_W'(el_rd_ff);
            run_end_in = (k_ff == last_idx);
            dropped_in = ovf_ff;
            if (k_ff == last_idx) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               sp_in    = '0;
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               el_raddr = k_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_sorted_value  = value_ff;
   assign rsp_run_end       = run_end_ff;
   assign rsp_dropped_items = dropped_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STORE_DEPTH))
      else $error("element count beyond store depth");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CNT_W'(STORE_DEPTH))
      else $error("range stack overrun");

   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_I_CHK || state_ff == ST_J_CHK) |->
         (i_ff >= lo_ff && i_ff <= hi_ff && j_ff >= lo_ff && j_ff <= hi_ff))
      else $error("partition index outside its range");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EMIT))
      else $error("result strobe outside emit phase");

   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_is_final) |=> busy)
      else $error("final transfer did not start the sort");
`endif

endmodule

// ===== tb/sv/tb_quicksort_hoare_sort_engine.sv =====
// Self-checking testbench for quicksort_hoare_sort_engine: loads sets of signed samples,
// predicts the sorted output run per set and checks every result field by field.
// Depends on qsort_pkg and the quicksort_hoare_sort_engine RTL.
`timescale 1ns / 1ps

module tb_quicksort_hoare_sort_engine;
   import qsort_pkg::*;

   localparam int DEPTH          = 64;
   localparam int ITEM_TARGET    = 310;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 32'h8000_0000;
   localparam logic signed [SAMPLE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      bit                         run_end;
      bit                         dropped;
   } sorted_result_t;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      bit                         is_last;
      bit                         has_answer;
      logic signed [SAMPLE_W-1:0] answer;
   } stim_row_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic                       req_is_final = 1'b0;
   logic                       rsp_strobe;
   logic signed [SAMPLE_W-1:0] rsp_sorted_value;
   logic                       rsp_run_end;
   logic                       rsp_dropped_items;

   // predictor state: biased keys so that unsigned order is signed order
   logic [SAMPLE_W-1:0] held_key [DEPTH];
   int                  held_count;
   bit                  overflow_flag;
   int                  span_lo [DEPTH];
   int                  span_hi [DEPTH];
   int                  span_top;

   sorted_result_t sorted_q [$];
   stim_row_t      directed_rows [20];

   int  items_sent;
   int  sets_done;
   int  overflow_sets;
   int  results_seen;
   int  mismatches;
   int  idle_cycles;
   bit  no_gaps;

   quicksort_hoare_sort_engine #(
      .STORE_DEPTH(DEPTH),
      .VALUE_WIDTH(SAMPLE_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sample_value(req_sample_value),
      .req_is_final(req_is_final),
      .rsp_strobe(rsp_strobe),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_run_end(rsp_run_end),
      .rsp_dropped_items(rsp_dropped_items)
   );

   always #1 clock = ~clock;

   function automatic void push_span(int lo, int hi);
      if (lo >= hi || span_top >= DEPTH) return;
      span_lo[span_top] = lo;
      span_hi[span_top] = hi;
      span_top++;
   endfunction

   function automatic int hoare_split(int lo, int hi);
      logic [SAMPLE_W-1:0] pivot;
      logic [SAMPLE_W-1:0] swap_key;
      int i;
      int j;
      bit first_pass;
      pivot = held_key[lo];
      i = lo;
      j = hi;
      first_pass = 1'b1;
      forever begin
         if (!first_pass) begin
            i++;
            j--;
         end
         first_pass = 1'b0;
         while (i < hi && held_key[i] < pivot) i++;
         while (j > lo && held_key[j] > pivot) j--;
         if (i < j) begin
            swap_key = held_key[i];
            held_key[i] = held_key[j];
            held_key[j] = swap_key;
         end else begin
            return j;
         end
      end
   endfunction

   function automatic void sort_held_keys(int n);
      int lo;
      int hi;
      int p;
      span_top = 0;
      if (n < 2) return;
      push_span(0, n - 1);
      while (span_top > 0) begin
         span_top--;
         lo = span_lo[span_top];
         hi = span_hi[span_top];
         if (lo >= hi) continue;
         p = hoare_split(lo, hi);
         if (p >= hi) p = hi - 1;
         push_span(p + 1, hi);
         push_span(lo, p);
      end
   endfunction

   // update the predictor with one accepted transfer; queue the run on a final item
   function automatic void absorb_sample(stim_row_t row);
      sorted_result_t res;
      int n;
      items_sent++;
      if (held_count < DEPTH) begin
         held_key[held_count] = row.value ^ SIGN_FLIP;
         held_count++;
      end else begin
         overflow_flag = 1'b1;
      end
      if (!row.is_last) return;
      n = held_count;
      sort_held_keys(n);
      if (row.has_answer) begin
         res.value   = row.answer;
         res.run_end = 1'b1;
         res.dropped = 1'b0;
         sorted_q.push_back(res);
      end else begin
         for (int k = 0; k < n; k++) begin
            res.value   = held_key[k] ^ SIGN_FLIP;
            res.run_end = (k == n - 1);
            res.dropped = overflow_flag;
            sorted_q.push_back(res);
         end
      end
      sets_done++;
      if (overflow_flag) overflow_sets++;
      held_count    = 0;
      span_top      = 0;
      overflow_flag = 1'b0;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 9);
      if (roll < 5) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return $signed($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return '0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   task automatic send_row(stim_row_t row);
      int gap;
      gap = pick_gap();
      for (int k = 0; k < gap; k++) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_sample_value <= row.value;
      req_is_final     <= row.is_last;
      do @(posedge clock); while (busy);
      absorb_sample(row);
   endtask

   task automatic send_random_set(int set_len);
      stim_row_t row;
      logic signed [SAMPLE_W-1:0] base;
      int shape;
      shape   = $urandom_range(0, 4);
      base    = $urandom;
      no_gaps = ($urandom_range(0, 9) < 3);
      for (int k = 0; k < set_len; k++) begin
         case (shape)
            2: row.value = base + k;
            3: row.value = base - k;
            4: row.value = $signed($urandom_range(0, 2)) - 1;
            default: row.value = rand_sample();
         endcase
         row.is_last    = (k == set_len - 1);
         row.has_answer = 1'b0;
         row.answer     = '0;
         send_row(row);
      end
   endtask

   function automatic void report_mismatch(string what, sorted_result_t want,
                                           bit have_want);
      mismatches++;
      if (mismatches > REPORT_LIMIT) return;
      if (have_want)
         $display("%0t: %s: expected value=%0d end=%0b drop=%0b, got value=%0d end=%0b drop=%0b",
                  $realtime, what, want.value, want.run_end, want.dropped,
                  rsp_sorted_value, rsp_run_end, rsp_dropped_items);
      else
         $display("%0t: %s: got value=%0d end=%0b drop=%0b", $realtime, what,
                  rsp_sorted_value, rsp_run_end, rsp_dropped_items);
   endfunction

   always @(posedge clock) begin : result_check
      sorted_result_t want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (sorted_q.size() == 0) begin
            want = '{default: '0};
            report_mismatch("unexpected result", want, 1'b0);
         end else begin
            want = sorted_q.pop_front();
            if (rsp_sorted_value !== want.value || rsp_run_end !== want.run_end ||
                rsp_dropped_items !== want.dropped)
               report_mismatch("result mismatch", want, 1'b1);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                  sorted_q.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      held_count    = 0;
      overflow_flag = 1'b0;
      span_top      = 0;
      items_sent    = 0;
      sets_done     = 0;
      overflow_sets = 0;
      no_gaps       = 1'b0;
      directed_rows = '{
         '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
         '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
         '{32'sd0,  1'b1, 1'b1, 32'sd0},
         '{-32'sd1, 1'b1, 1'b1, -32'sd1},
         '{32'sd5,  1'b0, 1'b0, 32'sd0},
         '{-32'sd3, 1'b0, 1'b0, 32'sd0},
         '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
         '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
         '{32'sd0,  1'b0, 1'b0, 32'sd0},
         '{-32'sd1, 1'b1, 1'b0, 32'sd0},
         '{32'sd4,  1'b0, 1'b0, 32'sd0},
         '{32'sd3,  1'b0, 1'b0, 32'sd0},
         '{32'sd2,  1'b0, 1'b0, 32'sd0},
         '{32'sd1,  1'b1, 1'b0, 32'sd0},
         '{32'sd7,  1'b0, 1'b0, 32'sd0},
         '{32'sd7,  1'b0, 1'b0, 32'sd0},
         '{-32'sd7, 1'b0, 1'b0, 32'sd0},
         '{32'sd7,  1'b1, 1'b0, 32'sd0},
         '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
         '{VAL_MIN, 1'b1, 1'b0, 32'sd0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) send_row(directed_rows[r]);

      // overflow with the final item itself dropped, then an exactly full store
      send_random_set(DEPTH + 1);
      send_random_set(DEPTH);
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 15) == 0)
            send_random_set($urandom_range(DEPTH - 4, DEPTH + 4));
         else
            send_random_set($urandom_range(1, 10));
      end
      start <= 1'b0;

      while (sorted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sorted %0d sets from %0d samples (%0d sets overflowed the store).",
               sets_done, items_sent, overflow_sets);
      $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0 && sorted_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
